// File: hdl/peds_pkg.sv
package peds_pkg;

   // Grid geometry
   localparam int MAX_WIDTH  = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int GRID_W_W   = 11;

   // Field widths
   localparam int LEVEL_W    = 32;
   localparam int FACTOR_W   = 17;
   localparam int BOUND_W    = 31;
   localparam int QUARTER_W  = FACTOR_W - 2;
   localparam int WIDE_W     = LEVEL_W + 3;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;
   localparam logic [CSR_IDX_W-1:0] CSR_RETAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPREAD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CEILING = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH   = 3'd4;

   // Reset values of the configuration registers
   localparam logic [FACTOR_W-1:0] RETAIN_RESET  = 17'd65536;
   localparam logic [FACTOR_W-1:0] SPREAD_RESET  = 17'd0;
   localparam logic [BOUND_W-1:0]  CEILING_RESET = 31'h7fff_ffff;
   localparam logic [BOUND_W-1:0]  FLOOR_RESET   = 31'd0;
   localparam logic [GRID_W_W-1:0] WIDTH_RESET   = GRID_W_W'(MAX_WIDTH);

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   typedef struct packed {
      logic [FACTOR_W-1:0] retain_factor;
      logic [FACTOR_W-1:0] spread_factor;
      logic [BOUND_W-1:0]  ceiling_level;
      logic [BOUND_W-1:0]  floor_level;
      logic [GRID_W_W-1:0] grid_width;
   } cfg_type;

   // One evaporated cell on its way to the line stores
   typedef struct packed {
      logic               flush;
      logic               blocked;
      logic [LEVEL_W-1:0] level;
   } cell_type;

   // Ceiling first, then floor
   function automatic logic [LEVEL_W-1:0] bound_level(input logic signed [WIDE_W-1:0] v,
                                                       input logic [BOUND_W-1:0] ceil_lvl,
                                                       input logic [BOUND_W-1:0] floor_lvl);
      logic signed [WIDE_W-1:0] c;
      logic signed [WIDE_W-1:0] f;
      logic signed [WIDE_W-1:0] t;
      c = $signed({{(WIDE_W-BOUND_W){1'b0}}, ceil_lvl});
      f = $signed({{(WIDE_W-BOUND_W){1'b0}}, floor_lvl});
      t = (v > c) ? c : v;
      return (t < f) ? '0 : t[LEVEL_W-1:0];
   endfunction

endpackage

// File: hdl/peds_front.sv
module peds_front (
   input  logic               clock,
   input  logic               reset,
   input  peds_pkg::cfg_type  cfg,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_cell_level,
   input  logic               req_cell_blocked,
   input  logic               req_flush_row,
   output logic               push_valid,
   output peds_pkg::cell_type push_cell,
   input  logic               push_full
);
   import peds_pkg::*;

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_neg_ff;
   logic                 s1_blocked_ff;
   logic                 s1_flush_ff;
   logic [LEVEL_W-1:0]   s1_prod_ff;
   logic [LEVEL_W+15:0]  prod_full;
   logic                 accept;

   // Stage holds one word; it stalls only when the queue is full
   assign req_stall = s1_valid_ff & push_full;
   assign accept    = req_valid & ~req_stall;

   // Evaporation product of the level and the Q1.16 retain factor, truncated
   assign prod_full = (LEVEL_W+16)'(req_cell_level[LEVEL_W-2:0])
                    * (LEVEL_W+16)'(cfg.retain_factor);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (!push_full) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_neg_ff     <= req_cell_level[LEVEL_W-1];
         s1_blocked_ff <= req_cell_blocked;
         s1_flush_ff   <= req_flush_row;
         s1_prod_ff    <= prod_full[LEVEL_W+15:16];
      end
   end

   // Clamp and classify; a flush cell acts as blocked
   assign push_valid        = s1_valid_ff;
   assign push_cell.flush   = s1_flush_ff;
   assign push_cell.blocked = s1_blocked_ff | s1_flush_ff;
   assign push_cell.level   = s1_neg_ff ? '0
                            : bound_level($signed(WIDE_W'(s1_prod_ff)),
                                          cfg.ceiling_level, cfg.floor_level);

endmodule

// File: hdl/peds_queue.sv
module peds_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  peds_pkg::cell_type push_cell,
   output logic               push_full,
   output logic               pop_valid,
   output peds_pkg::cell_type pop_cell,
   input  logic               pop_ready
);
   import peds_pkg::*;

   cell_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign push_full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cell  = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid & ~push_full;
   assign do_pop    = pop_ready & pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cell;
      end
   end

endmodule

// File: hdl/peds_back.sv
module peds_back (
   input  logic               clock,
   input  logic               reset,
   input  peds_pkg::cfg_type  cfg,
   input  logic               pop_valid,
   input  peds_pkg::cell_type pop_cell,
   output logic               pop_ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_new_level,
   output logic               rsp_frame_last
);
   import peds_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SUM  = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   localparam logic [1:0] ROWS_NONE = 2'd0;
   localparam logic [1:0] ROWS_ONE  = 2'd1;
   localparam logic [1:0] ROWS_MANY = 2'd2;

   // Line stores: bit 32 blocked, bits 31..0 evaporated level
   logic [LEVEL_W:0] newer_mem [MAX_WIDTH];
   logic [LEVEL_W:0] older_mem [MAX_WIDTH];

   logic [1:0]          state_ff, state_in;
   logic [1:0]          rows_ff, rows_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]  rsp_level_ff;
   logic                rsp_last_ff;

   // Per-cell working registers
   logic [COL_W-1:0]    x_ff;
   logic [LEVEL_W:0]    item_ff;
   logic                emit_ff, left_ok_ff, right_ok_ff, up_ok_ff, last_ff;
   logic [LEVEL_W:0]    center_rd_ff, right_rd_ff, up_rd_ff;
   logic [LEVEL_W:0]    prev_ff;
   logic [LEVEL_W-1:0]  here_ff;
   logic                center_blk_ff;
   logic [LEVEL_W+1:0]  inflow_ff, inflow_in;
   logic [FACTOR_W-1:0] outflow_ff, outflow_in;
   logic [LEVEL_W:0]    drain_ff, gain_ff;

   logic [GRID_W_W-1:0]  w_eff;
   logic [COL_W-1:0]     x_cur;
   logic [GRID_W_W-1:0]  x_next;
   logic                 row_end;
   logic                 drop;
   logic                 issue;
   logic                 wr_en;
   logic                 mul_en;
   logic                 load_rsp;
   logic [QUARTER_W-1:0] quarter;
   logic                 left_open, right_open, up_open, down_open;
   logic [2:0]           open_cnt;
   logic [LEVEL_W+16:0]  drain_prod, gain_prod;
   logic signed [WIDE_W-1:0] mix;

   assign quarter = cfg.spread_factor[FACTOR_W-1:2];

   // Column decode with width clamped to 1..MAX_WIDTH
   always_comb begin
      if (cfg.grid_width == '0) begin
         w_eff = GRID_W_W'(1);
      end else if (cfg.grid_width > GRID_W_W'(MAX_WIDTH)) begin
         w_eff = GRID_W_W'(MAX_WIDTH);
      end else begin
         w_eff = cfg.grid_width;
      end
      x_cur   = (GRID_W_W'(col_ff) >= w_eff) ? '0 : col_ff;
      x_next  = GRID_W_W'(x_cur) + GRID_W_W'(1);
      row_end = (x_next >= w_eff);
      drop    = pop_cell.flush & (rows_ff == ROWS_NONE);
   end

   // Neighbour sums from the store reads
   always_comb begin
      left_open  = left_ok_ff  & ~prev_ff[LEVEL_W];
      right_open = right_ok_ff & ~right_rd_ff[LEVEL_W];
      up_open    = up_ok_ff    & ~up_rd_ff[LEVEL_W];
      down_open  = ~item_ff[LEVEL_W];
      inflow_in  = (left_open  ? (LEVEL_W+2)'(prev_ff[LEVEL_W-1:0])      : '0)
                 + (right_open ? (LEVEL_W+2)'(right_rd_ff[LEVEL_W-1:0])  : '0)
                 + (up_open    ? (LEVEL_W+2)'(up_rd_ff[LEVEL_W-1:0])     : '0)
                 + (down_open  ? (LEVEL_W+2)'(item_ff[LEVEL_W-1:0])      : '0);
      open_cnt   = 3'(left_open) + 3'(right_open) + 3'(up_open) + 3'(down_open);
      outflow_in = FACTOR_W'(open_cnt) * FACTOR_W'(quarter);
   end

   // Exchange products
   assign drain_prod = (LEVEL_W+17)'(here_ff)   * (LEVEL_W+17)'(outflow_ff);
   assign gain_prod  = (LEVEL_W+17)'(inflow_ff) * (LEVEL_W+17)'(quarter);

   assign mix = $signed({3'b000, here_ff}) - $signed({2'b00, drain_ff})
              + $signed({2'b00, gain_ff});

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      rows_in      = rows_ff;
      col_in       = col_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      pop_ready    = 1'b0;
      issue        = 1'b0;
      wr_en        = 1'b0;
      mul_en       = 1'b0;
      load_rsp     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               pop_ready = 1'b1;
               if (!drop) begin
                  issue    = 1'b1;
                  state_in = ST_SUM;
                  col_in   = row_end ? '0 : x_next[COL_W-1:0];
                  if (row_end) begin
                     if (pop_cell.flush) begin
                        rows_in = ROWS_NONE;
                     end else if (rows_ff != ROWS_MANY) begin
                        rows_in = rows_ff + 2'd1;
                     end
                  end
               end
            end
         end
         ST_SUM: begin
            wr_en    = 1'b1;
            state_in = emit_ff ? ST_MUL : ST_IDLE;
         end
         ST_MUL: begin
            mul_en   = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_ff      <= ROWS_NONE;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Line store access: read on issue, write back in the next cycle (ST_SUM)
   always_ff @(posedge clock) begin
      if (issue) begin
         center_rd_ff <= newer_mem[x_cur];
         right_rd_ff  <= newer_mem[x_next[COL_W-1:0]];
         up_rd_ff     <= older_mem[x_cur];
      end
      if (wr_en) begin
         older_mem[x_ff] <= center_rd_ff;
         newer_mem[x_ff] <= item_ff;
      end
   end

   // Working payload
   always_ff @(posedge clock) begin
      if (issue) begin
         x_ff        <= x_cur;
         item_ff     <= {pop_cell.blocked, pop_cell.level};
         emit_ff     <= (rows_ff != ROWS_NONE);
         up_ok_ff    <= (rows_ff == ROWS_MANY);
         left_ok_ff  <= (x_cur != '0);
         right_ok_ff <= ~row_end;
         last_ff     <= pop_cell.flush & row_end;
      end
      if (wr_en) begin
         prev_ff       <= center_rd_ff;
         here_ff       <= center_rd_ff[LEVEL_W-1:0];
         center_blk_ff <= center_rd_ff[LEVEL_W];
         inflow_ff     <= inflow_in;
         outflow_ff    <= outflow_in;
      end
      if (mul_en) begin
         drain_ff <= drain_prod[LEVEL_W+16:16];
         gain_ff  <= gain_prod[LEVEL_W+16:16];
      end
      if (load_rsp) begin
         rsp_level_ff <= center_blk_ff ? '0
                       : bound_level(mix, cfg.ceiling_level, cfg.floor_level);
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_new_level  = $signed(rsp_level_ff);
   assign rsp_frame_last = rsp_last_ff;

endmodule

// File: hdl/pheromone_evaporate_diffuse_stencil_unit.sv
// Channel   Direction  Handshake           Word
// req       in         req_valid/req_stall  cell_level, cell_blocked, flush_row
// rsp       out        rsp_valid/rsp_stall  new_level, frame_last
// csr       in         csr_wr_en            csr_index, csr_wdata
//
// Front: a registered evaporation stage, then the queue. The back end runs store read,
// sum, multiply and bound one cell at a time; first-row cells stop after the sum and
// a dropped flush is only popped. Bound waits while a stalled rsp word is held.
// Synchronous active-high reset clears the control state; the line stores hold
// garbage until written and need no clearing pass.
// A stalled rsp word holds in its register while the front keeps filling the queue.
module pheromone_evaporate_diffuse_stencil_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [31:0]               req_cell_level,
   input  logic                             req_cell_blocked,
   input  logic                             req_flush_row,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [31:0]               rsp_new_level,
   output logic                             rsp_frame_last,
   input  logic                             csr_wr_en,
   input  logic [peds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [peds_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import peds_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     push_valid;
   cell_type push_cell;
   logic     push_full;
   logic     pop_valid;
   cell_type pop_cell;
   logic     pop_ready;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RETAIN:  cfg_in.retain_factor = csr_wdata[FACTOR_W-1:0];
            CSR_SPREAD:  cfg_in.spread_factor = csr_wdata[FACTOR_W-1:0];
            CSR_CEILING: cfg_in.ceiling_level = csr_wdata[BOUND_W-1:0];
            CSR_FLOOR:   cfg_in.floor_level   = csr_wdata[BOUND_W-1:0];
            CSR_WIDTH:   cfg_in.grid_width    = csr_wdata[GRID_W_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retain_factor <= RETAIN_RESET;
         cfg_ff.spread_factor <= SPREAD_RESET;
         cfg_ff.ceiling_level <= CEILING_RESET;
         cfg_ff.floor_level   <= FLOOR_RESET;
         cfg_ff.grid_width    <= WIDTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   peds_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cell_level   (req_cell_level),
      .req_cell_blocked (req_cell_blocked),
      .req_flush_row    (req_flush_row),
      .push_valid       (push_valid),
      .push_cell        (push_cell),
      .push_full        (push_full)
   );

   peds_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cell  (push_cell),
      .push_full  (push_full),
      .pop_valid  (pop_valid),
      .pop_cell   (pop_cell),
      .pop_ready  (pop_ready)
   );

   peds_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .pop_valid      (pop_valid),
      .pop_cell       (pop_cell),
      .pop_ready      (pop_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_new_level  (rsp_new_level),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import peds_pkg::*;

   // One input word and one result word
   typedef struct {
      logic signed [LEVEL_W-1:0] level;
      logic                      blocked;
      logic                      flush;
   } cell_word_type;

   typedef struct {
      logic signed [LEVEL_W-1:0] level;
      logic                      last;
   } level_word_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic signed [31:0]      req_cell_level = '0;
   logic                    req_cell_blocked = 1'b0;
   logic                    req_flush_row = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [31:0]      rsp_new_level;
   logic                    rsp_frame_last;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   pheromone_evaporate_diffuse_stencil_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cell_level   (req_cell_level),
      .req_cell_blocked (req_cell_blocked),
      .req_flush_row    (req_flush_row),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_new_level    (rsp_new_level),
      .rsp_frame_last   (rsp_frame_last),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the block: settings, two line stores, raster position
   logic [FACTOR_W-1:0] retain_q;
   logic [FACTOR_W-1:0] spread_q;
   logic [BOUND_W-1:0]  ceiling_q;
   logic [BOUND_W-1:0]  floor_q;
   logic [GRID_W_W-1:0] width_q;
   logic [32:0]         row_back2 [MAX_WIDTH];
   logic [32:0]         row_back1 [MAX_WIDTH];
   int unsigned         col_q;
   int unsigned         rows_q;

   cell_word_type       cells_pending [$];
   level_word_type      levels_due [$];
   cell_word_type       on_bus;
   int                  words_queued = 0;
   int                  levels_seen = 0;
   int                  errors = 0;
   int                  cyc = 0;
   logic                calm;

   always @(posedge clock) cyc <= cyc + 1;

   // no random idling on either side through this stretch
   assign calm = (cyc >= 1500) && (cyc < 3000);

   // Ceiling first, then floor
   function automatic longint limit_level(input longint v);
      if (v > longint'(ceiling_q))
         v = longint'(ceiling_q);
      if (v < longint'(floor_q))
         v = 0;
      return v;
   endfunction

   function automatic logic [31:0] evaporate(input logic signed [31:0] lvl);
      longint p;
      if (lvl[31])
         return '0;
      p = limit_level((longint'(lvl[30:0]) * longint'(retain_q)) >>> 16);
      return p[31:0];
   endfunction

   // Advance the shadow by one accepted word; queue the word it emits, if any
   task automatic step_stencil(input cell_word_type c);
      int unsigned w;
      int unsigned x;
      int          k;
      logic [32:0] cur;
      logic [32:0] mid;
      logic [32:0] nb [4];
      bit          live [4];
      longint      here;
      longint      inflow;
      longint      outflow;
      longint      quarter;
      longint      v;
      w = width_q;
      if (w == 0)
         w = 1;
      if (w > MAX_WIDTH)
         w = MAX_WIDTH;
      x = (col_q >= w) ? 0 : col_q;
      // flush with no row yet: dropped
      if (c.flush && rows_q == 0)
         return;
      cur = c.flush ? {1'b1, 32'd0} : {c.blocked, evaporate(c.level)};
      if (rows_q >= 1) begin
         mid     = row_back1[x];
         nb[0]   = (x > 0) ? row_back2[x-1] : '0;
         live[0] = x > 0;
         nb[1]   = (x + 1 < w) ? row_back1[x+1] : '0;
         live[1] = x + 1 < w;
         nb[2]   = row_back2[x];
         live[2] = rows_q >= 2;
         nb[3]   = cur;
         live[3] = 1'b1;
         v = 0;
         if (!mid[32]) begin
            here    = mid[31:0];
            inflow  = 0;
            outflow = 0;
            quarter = spread_q >> 2;
            for (k = 0; k < 4; k++) begin
               if (live[k] && !nb[k][32]) begin
                  inflow  += nb[k][31:0];
                  outflow += quarter;
               end
            end
            v = here - ((here * outflow) >>> 16) + ((inflow * quarter) >>> 16);
            v = limit_level(v);
         end
         levels_due.push_back('{level: v[31:0], last: c.flush && (x + 1 == w)});
      end
      row_back2[x] = row_back1[x];
      row_back1[x] = cur;
      x++;
      if (x >= w) begin
         x = 0;
         if (c.flush)
            rows_q = 0;
         else if (rows_q < 2)
            rows_q++;
      end
      col_q = x;
   endtask

   // Sender: holds a word until taken, idles at random between words
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            step_stencil(on_bus);
         if (!req_valid || !req_stall) begin
            if (cells_pending.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
               on_bus = cells_pending.pop_front();
               req_valid        <= 1'b1;
               req_cell_level   <= on_bus.level;
               req_cell_blocked <= on_bus.blocked;
               req_flush_row    <= on_bus.flush;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall: one long hold-off early on, random stalls otherwise
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && levels_seen >= 300) begin
         rsp_stall <= 1'b1;
         hold_left <= 400;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 19);
      end
   end

   // Result check against the oldest expected word
   always @(posedge clock) begin : rsp_check
      level_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (levels_due.size() == 0) begin
            $error("unexpected word: new_level %0d frame_last %0b",
                   rsp_new_level, rsp_frame_last);
            errors++;
         end else begin
            want = levels_due.pop_front();
            if (rsp_new_level !== want.level) begin
               $error("new_level: expected %0d actual %0d", want.level, rsp_new_level);
               errors++;
            end
            if (rsp_frame_last !== want.last) begin
               $error("frame_last: expected %0b actual %0b", want.last, rsp_frame_last);
               errors++;
            end
         end
         levels_seen <= levels_seen + 1;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_RETAIN:  retain_q  = data[FACTOR_W-1:0];
         CSR_SPREAD:  spread_q  = data[FACTOR_W-1:0];
         CSR_CEILING: ceiling_q = data[BOUND_W-1:0];
         CSR_FLOOR:   floor_q   = data[BOUND_W-1:0];
         CSR_WIDTH:   width_q   = data[GRID_W_W-1:0];
         default: ;
      endcase
   endtask

   task automatic close_writes();
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] retain,
                                 input logic [CSR_DATA_W-1:0] spread,
                                 input logic [CSR_DATA_W-1:0] ceil_lvl,
                                 input logic [CSR_DATA_W-1:0] floor_lvl,
                                 input logic [CSR_DATA_W-1:0] width);
      write_reg(CSR_RETAIN, retain);
      write_reg(CSR_SPREAD, spread);
      write_reg(CSR_CEILING, ceil_lvl);
      write_reg(CSR_FLOOR, floor_lvl);
      write_reg(CSR_WIDTH, width);
      close_writes();
   endtask

   // Wait for every word taken and every result back, then let the pipe empty
   task automatic settle();
      do
         @(negedge clock);
      while (cells_pending.size() != 0 || req_valid || levels_due.size() != 0);
      repeat (64) @(negedge clock);
   endtask

   function automatic logic signed [31:0] pick_level();
      case ($urandom_range(7))
         0:       return $urandom();
         1:       return $urandom_range(32'h3FFFF, 0);
         2:       return 32'h7FFF_FFFF;
         3:       return {1'b1, 31'($urandom())};
         default: return {1'b0, 31'($urandom())};
      endcase
   endfunction

   task automatic push_cell(input logic signed [31:0] lvl, input logic blk);
      cells_pending.push_back('{level: lvl, blocked: blk, flush: 1'b0});
      words_queued++;
   endtask

   // flush words carry junk in the ignored fields
   task automatic push_flush(input int n);
      repeat (n) begin
         cells_pending.push_back('{level: $urandom(), blocked: 1'($urandom_range(1)),
                                   flush: 1'b1});
         words_queued++;
      end
   endtask

   task automatic push_random_cell();
      push_cell(pick_level(), $urandom_range(99) < 15);
   endtask

   // Data rows with random content, then the closing flush row
   task automatic push_frame(input int w, input int rows, input bit noisy);
      bit mixed;
      repeat (rows) begin
         mixed = noisy && ($urandom_range(9) == 0);
         repeat (w) begin
            if (noisy && $urandom_range(19) == 0)
               push_flush(1);
            if (mixed && $urandom_range(1) == 0)
               push_flush(1);
            else
               push_random_cell();
         end
      end
      push_flush(w);
   endtask

   task automatic random_settings(output int w_eff);
      logic [CSR_DATA_W-1:0] retain;
      logic [CSR_DATA_W-1:0] spread;
      logic [CSR_DATA_W-1:0] ceil_lvl;
      logic [CSR_DATA_W-1:0] floor_lvl;
      logic [CSR_DATA_W-1:0] width;
      case ($urandom_range(9))
         0:       retain = 0;
         1:       retain = 65536;
         2:       retain = CSR_DATA_W'($urandom_range(131071, 65537));
         default: retain = CSR_DATA_W'($urandom_range(65536, 32768));
      endcase
      case ($urandom_range(9))
         0:       spread = 0;
         1:       spread = 65536;
         2:       spread = CSR_DATA_W'($urandom_range(131071, 65537));
         default: spread = CSR_DATA_W'($urandom_range(65536, 0));
      endcase
      case ($urandom_range(9))
         0:       ceil_lvl = 0;
         1:       ceil_lvl = 31'h7FFF_FFFF;
         2:       ceil_lvl = CSR_DATA_W'($urandom_range(32'h0010_0000, 0));
         default: ceil_lvl = CSR_DATA_W'($urandom_range(32'h7FFF_FFFF, 32'h4000_0000));
      endcase
      case ($urandom_range(9))
         0:       floor_lvl = 31'h7FFF_FFFF;
         1:       floor_lvl = CSR_DATA_W'($urandom_range(32'h7FFF_FFFF, 0));
         2, 3:    floor_lvl = CSR_DATA_W'($urandom_range(32'h0001_0000, 0));
         default: floor_lvl = 0;
      endcase
      case ($urandom_range(9))
         0:       width = 1;
         1:       width = 0;
         2:       width = CSR_DATA_W'($urandom_range(48, 9));
         default: width = CSR_DATA_W'($urandom_range(8, 2));
      endcase
      apply_settings(retain, spread, ceil_lvl, floor_lvl, width);
      w_eff = (width == 0) ? 1 : int'(width);
   endtask

   initial begin : stimulus
      int w_eff;
      int start_count;
      retain_q  = RETAIN_RESET;
      spread_q  = SPREAD_RESET;
      ceiling_q = CEILING_RESET;
      floor_q   = FLOOR_RESET;
      width_q   = WIDTH_RESET;
      col_q     = 0;
      rows_q    = 0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         row_back2[i] = '0;
         row_back1[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Settings from reset: leading flushes are dropped, a partial first row gives nothing
      push_flush(2);
      repeat (6) push_random_cell();
      settle();

      // Three wide: extreme levels, negative levels, blocked cells, spread above one
      apply_settings(49152, 131071, 31'h7FFF_FFFF, 0, 3);
      push_cell(32'h7FFF_FFFF, 1'b0);
      push_cell(32'h8000_0000, 1'b0);
      push_cell(32'h0001_0000, 1'b1);
      push_cell(32'h0000_0000, 1'b0);
      push_cell(32'h7FFF_FFFF, 1'b0);
      push_cell(32'hFFFF_FFFF, 1'b0);
      push_flush(3);
      settle();

      // Width zero acts as one; retain above one saturates at the ceiling
      apply_settings(131071, 65536, 31'h7FFF_FFFF, 16, 0);
      push_cell(32'h4000_0000, 1'b0);
      push_cell(32'h0000_0010, 1'b0);
      push_cell(32'h7FFF_FFFF, 1'b0);
      push_flush(1);
      settle();

      // Ceiling below floor: everything comes out zero
      apply_settings(65536, 16384, 1000, 2000, 2);
      push_cell(5000, 1'b0);
      push_cell(100, 1'b0);
      push_cell(3000, 1'b0);
      push_cell(32'h7FFF_FFFF, 1'b1);
      push_flush(2);
      settle();

      // Width lowered in mid-row: the next word restarts at column zero
      apply_settings(65536, 32768, 31'h7FFF_FFFF, 0, 3);
      repeat (5) push_random_cell();
      settle();
      write_reg(CSR_WIDTH, 1);
      close_writes();
      push_random_cell();
      push_flush(1);
      settle();

      // Random settings, well-formed frames with some noise mixed in
      start_count = words_queued;
      while (words_queued - start_count < 800) begin
         random_settings(w_eff);
         push_frame(w_eff, $urandom_range(6, 1), 1'b1);
         if ($urandom_range(4) == 0)
            push_frame(w_eff, $urandom_range(3, 1), 1'b1);
         settle();
      end

      if (errors == 0 && levels_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #3_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
